// ===== sv/bfpu_pkg.sv =====
// shared types and constants of the bit field packer and unpacker
`default_nettype none

package bfpu_pkg;

  // buffer geometry
  localparam int BUF_BYTES      = 256;
  localparam int ADDR_W         = $clog2(BUF_BYTES);
  localparam int CAP_BITS       = BUF_BYTES * 8;
  localparam int MAX_FIELD_BITS = 32;

  // fixed field widths
  localparam int CMD_W = 3;
  localparam int FB_W  = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 12;
  localparam int ST_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REPLACE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FETCH_LSB = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FETCH_MSB = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_REPL_OOR  = 2'd1;
  localparam logic [ST_W-1:0] ST_FETCH_END = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [FB_W-1:0]  field_bits;
    logic [VAL_W-1:0] field_value;
    logic [LEN_W-1:0] bit_position;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length_bits;
    logic [LEN_W-1:0] read_pos;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/bit_field_packer_unpacker.sv =====
// bit field packer and unpacker: command sequencer around a byte-wide buffer memory
// Sequence: a command touching k buffer bytes (1 to 5) runs S_RD and S_MOD per byte,
// then S_FIN, after which the result strobe rises; clear, zero-width and failing
// commands go straight to S_FIN. Start is taken only while idle. Each byte needs a read
// and, on append/replace, a write of the single-port buffer. The receiver cannot stall.
// Reset: write length, read position and control clear; buffer contents stay undefined.
`default_nettype none

module bit_field_packer_unpacker (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic start,
  input  wire                bfpu_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output bfpu_pkg::rsp_t     rsp
);

  localparam int BIT_W = bfpu_pkg::LEN_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                     state;
  logic [bfpu_pkg::CMD_W-1:0]     op;
  logic [bfpu_pkg::ST_W-1:0]      status;
  logic [BIT_W-1:0]               write_length;
  logic [BIT_W-1:0]               read_position;
  logic [BIT_W-1:0]               bitp;
  logic [bfpu_pkg::FB_W-1:0]      rem;
  logic [bfpu_pkg::FB_W-1:0]      got;
  logic [bfpu_pkg::VAL_W-1:0]     val_sr;
  logic [bfpu_pkg::VAL_W-1:0]     acc;

  // buffer memory
  logic [7:0]                     mem [bfpu_pkg::BUF_BYTES];
  logic [bfpu_pkg::ADDR_W-1:0]    mem_addr;
  logic                           mem_we;
  logic [7:0]                     mem_wdata;
  logic [7:0]                     mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // command checks at accept
  logic                           accept;
  logic [bfpu_pkg::FB_W-1:0]      n_clip;
  logic [BIT_W:0]                 wl_sum;
  logic [BIT_W:0]                 pos_sum;
  logic [BIT_W:0]                 rp_sum;

  assign accept = start && !busy;
  assign n_clip = (req.field_bits > bfpu_pkg::FB_W'(bfpu_pkg::MAX_FIELD_BITS))
                  ? bfpu_pkg::FB_W'(bfpu_pkg::MAX_FIELD_BITS) : req.field_bits;
  assign wl_sum  = {1'b0, write_length} + (BIT_W+1)'(n_clip);
  assign pos_sum = {1'b0, req.bit_position} + (BIT_W+1)'(n_clip);
  assign rp_sum  = {1'b0, read_position} + (BIT_W+1)'(n_clip);

  // per-byte chunk of the field
  logic [2:0]                     off;
  logic [3:0]                     room;
  logic [3:0]                     take;
  logic [7:0]                     tmask;
  logic [7:0]                     chunk;
  logic [bfpu_pkg::FB_W-1:0]      rem_left;

  assign off      = bitp[2:0];
  assign room     = 4'd8 - {1'b0, off};
  assign take     = (bfpu_pkg::FB_W'(room) > rem) ? rem[3:0] : room;
  assign tmask    = 8'((9'd1 << take) - 9'd1);
  assign chunk    = (mem_rdata >> off) & tmask;
  assign rem_left = rem - bfpu_pkg::FB_W'(take);

  // memory port control
  always_comb begin
    mem_addr  = bitp[bfpu_pkg::ADDR_W+2:3];
    mem_we    = (state == S_MOD) &&
                (op == bfpu_pkg::CMD_APPEND || op == bfpu_pkg::CMD_REPLACE);
    mem_wdata = 8'((mem_rdata & ~8'(tmask << off)) | 8'((val_sr[7:0] & tmask) << off));
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      write_length  <= '0;
      read_position <= '0;
      op            <= bfpu_pkg::CMD_CLEAR;
      status        <= bfpu_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= req.cmd;
            rem    <= n_clip;
            got    <= '0;
            acc    <= '0;
            val_sr <= req.field_value;
            status <= bfpu_pkg::ST_OK;
            state  <= S_FIN;
            unique case (req.cmd)
              bfpu_pkg::CMD_CLEAR: begin
                write_length  <= '0;
                read_position <= '0;
              end
              bfpu_pkg::CMD_APPEND: begin
                if (wl_sum > (BIT_W+1)'(bfpu_pkg::CAP_BITS)) begin
                  status <= bfpu_pkg::ST_FULL;
                end else begin
                  bitp         <= write_length;
                  write_length <= wl_sum[BIT_W-1:0];
                  if (n_clip != '0) state <= S_RD;
                end
              end
              bfpu_pkg::CMD_REPLACE: begin
                if (pos_sum > {1'b0, write_length}) begin
                  status <= bfpu_pkg::ST_REPL_OOR;
                end else begin
                  bitp <= req.bit_position;
                  if (n_clip != '0) state <= S_RD;
                end
              end
              bfpu_pkg::CMD_FETCH_LSB, bfpu_pkg::CMD_FETCH_MSB: begin
                if (rp_sum > {1'b0, write_length}) begin
                  status <= bfpu_pkg::ST_FETCH_END;
                end else begin
                  bitp          <= read_position;
                  read_position <= rp_sum[BIT_W-1:0];
                  if (n_clip != '0) state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // read issued, data arrives next cycle
        S_RD: begin
          state <= S_MOD;
        end
        // merge or gather one byte
        S_MOD: begin
          val_sr <= val_sr >> take;
          if (op == bfpu_pkg::CMD_FETCH_LSB) begin
            acc <= acc | (bfpu_pkg::VAL_W'(chunk) << got);
          end else if (op == bfpu_pkg::CMD_FETCH_MSB) begin
            acc <= (acc << take) | bfpu_pkg::VAL_W'(chunk);
          end
          rem   <= rem_left;
          got   <= got + bfpu_pkg::FB_W'(take);
          bitp  <= bitp + BIT_W'(take);
          state <= (rem_left == '0) ? S_FIN : S_RD;
        end
        // result beat
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      rsp.read_value  <= acc;
      rsp.status      <= status;
      rsp.length_bits <= write_length;
      rsp.read_pos    <= read_position;
    end
  end

endmodule

`default_nettype wire
